// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL. Bodies compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== src/pes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_pkg
// Shared constants for the PUCT edge select unit: defaults, register
// indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam int EDGE_LIMIT_DEF = 256;
    localparam int VISIT_BITS_DEF = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_EXPLORATION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STYLE_WEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNVISITED_MODE = 2'd2;

    localparam logic [15:0] EXPLORATION_RST  = 16'd4096;
    localparam logic [15:0] STYLE_WEIGHT_RST = 16'd32768;

    localparam int RATE_W   = 16;
    localparam int VALUE_W  = 17;
    localparam int TERM_W   = 32;
    localparam int SCORE_W  = 48;
    localparam int INDEX_W  = 8;
    localparam int VCOUNT_W = 24;
    localparam int LOSS_W   = 8;

endpackage

// ===== src/puct_edge_select_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// puct_edge_select_unit
// Running PUCT argmax over the edges of one tree node.
// ----------------------------------------------------------------------------
// Usage: a header word (action 0) latches exploration * sqrt(node visits)
// and the parent value, then one edge word per child follows (action 1).
// The edge word with last set yields one result word: the best edge index,
// found and overflow. Header words and other edge words yield nothing.
// Input channel in_valid / in_stall, output channel out_valid / out_stall;
// a word moves on a rising edge with valid high and stall low.
// One word is processed at a time; in_stall is high while busy.
// A header word runs the square root on the shared subtract-compare unit.
// A scored edge runs the Q division (17 steps) when virtual loss is
// pending, then the U division (32 steps) on that same unit.
// Proven or surplus edges skip this arithmetic; one that ends the node
// goes on to the finish state.
// The result sits in an output register; if the receiver stalls while an
// older result waits, the block holds in its finish state.
// Reset loads register defaults, clears the node terms and the selection.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module puct_edge_select_unit #(
    parameter int EDGE_LIMIT = pes_pkg::EDGE_LIMIT_DEF,
    parameter int VISIT_BITS = pes_pkg::VISIT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pes_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pes_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [pes_pkg::VCOUNT_W-1:0]    visit_count,
    input  logic [pes_pkg::RATE_W-1:0]      win_rate,
    input  logic [pes_pkg::RATE_W-1:0]      draw_rate,
    input  logic [pes_pkg::RATE_W-1:0]      prior,
    input  logic [pes_pkg::LOSS_W-1:0]      pending_loss,
    input  logic                            proven,
    input  logic                            last,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [pes_pkg::INDEX_W-1:0]     selected_index,
    output logic                            found,
    output logic                            overflow
);

    localparam int VB  = VISIT_BITS;
    localparam int PB  = $clog2(EDGE_LIMIT + 1);
    localparam int RB  = (VB + 17) / 2;
    localparam int RW  = ((VB + 1) > (RB + 1)) ? (VB + 1) : (RB + 1);
    localparam int PW  = RW + 2;
    localparam int SHW = (2 * RB > 32) ? 2 * RB : 32;
    localparam int TW  = 12 + RB;
    localparam int QW  = pes_pkg::VALUE_W;
    localparam int NW  = QW + VB;
    localparam int CW  = 6;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQRT  = 4'd1;
    localparam logic [3:0] S_HMUL  = 4'd2;
    localparam logic [3:0] S_PREP  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_QDIV  = 4'd5;
    localparam logic [3:0] S_USTRT = 4'd6;
    localparam logic [3:0] S_UDIV  = 4'd7;
    localparam logic [3:0] S_SCORE = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    // configuration
    logic [15:0] exploration_reg;
    logic [15:0] style_weight_reg;
    logic        unvisited_mode_reg;

    // control
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // node terms and selection
    logic [pes_pkg::TERM_W-1:0]  sqrt_term_reg, sqrt_term_next;
    logic [QW-1:0]               parent_value_reg, parent_value_next;
    logic [pes_pkg::SCORE_W-1:0] best_score_reg, best_score_next;
    logic [pes_pkg::INDEX_W-1:0] best_index_reg, best_index_next;
    logic                        any_found_reg, any_found_next;
    logic [PB-1:0]               pos_reg, pos_next;
    logic                        ovf_reg, ovf_next;

    // latched word
    logic [VB-1:0]              v_reg, v_next;
    logic [pes_pkg::RATE_W-1:0] win_reg, win_next;
    logic [pes_pkg::RATE_W-1:0] draw_reg, draw_next;
    logic [pes_pkg::RATE_W-1:0] prior_reg, prior_next;
    logic [pes_pkg::LOSS_W-1:0] vl_reg, vl_next;
    logic                       last_reg, last_next;

    // datapath
    logic [QW-1:0]              base_reg, base_next;
    logic [QW-1:0]              q_reg, q_next;
    logic [pes_pkg::TERM_W-1:0] unum_reg, unum_next;
    logic [RW-1:0]              rem_reg, rem_next;
    logic [RW-1:0]              dvs_reg, dvs_next;
    logic [SHW-1:0]             sh_reg, sh_next;
    logic [RB-1:0]              root_reg, root_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [pes_pkg::INDEX_W-1:0] sel_reg, sel_next;
    logic                        found_reg, found_next;
    logic                        ovf_out_reg, ovf_out_next;

    logic                        in_acc;
    logic                        out_acc;
    logic                        loop_active;
    logic [PW-1:0]               partial;
    logic [PW-1:0]               operand;
    logic                        step_ok;
    logic [RW-1:0]               step_diff;
    logic [QW-1:0]               base_c;
    logic [31:0]                 sd_prod;
    logic [15+RB:0]              ex_prod;
    logic [TW-1:0]               t_val;
    logic [NW-1:0]               qnum;
    logic [47:0]                 u_prod;
    logic [pes_pkg::SCORE_W-1:0] score;
    logic [VB-1:0]               v_in;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign selected_index = sel_reg;
    assign found     = found_reg;
    assign overflow  = ovf_out_reg;
    assign v_in      = VB'(visit_count);
    assign loop_active = (state_reg == S_SQRT) || (state_reg == S_QDIV) ||
                         (state_reg == S_UDIV);

    // shared subtract-compare unit: root digit or quotient bit
    always_comb
    begin
        if (state_reg == S_SQRT)
        begin
            partial = {rem_reg, sh_reg[SHW-1 -: 2]};
            operand = PW'({root_reg, 2'b01});
        end
        else
        begin
            partial = {1'b0, rem_reg, sh_reg[SHW-1]};
            operand = {2'b00, dvs_reg};
        end
        step_ok   = (partial >= operand);
        step_diff = RW'(partial - operand);
    end

    // node and edge arithmetic around the shared unit
    always_comb
    begin
        sd_prod = style_weight_reg * draw_reg;
        base_c  = QW'(win_reg) + QW'(sd_prod[31:16]);
        ex_prod = exploration_reg * root_reg;
        t_val   = ex_prod[15+RB:4];
        qnum    = base_reg * v_reg;
        u_prod  = prior_reg * sqrt_term_reg;
        score   = pes_pkg::SCORE_W'(q_reg) + pes_pkg::SCORE_W'(sh_reg[31:0]);
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        sqrt_term_next    = sqrt_term_reg;
        parent_value_next = parent_value_reg;
        best_score_next   = best_score_reg;
        best_index_next   = best_index_reg;
        any_found_next    = any_found_reg;
        pos_next          = pos_reg;
        ovf_next          = ovf_reg;
        v_next            = v_reg;
        win_next          = win_reg;
        draw_next         = draw_reg;
        prior_next        = prior_reg;
        vl_next           = vl_reg;
        last_next         = last_reg;
        base_next         = base_reg;
        q_next            = q_reg;
        unum_next         = unum_reg;
        rem_next          = rem_reg;
        dvs_next          = dvs_reg;
        sh_next           = sh_reg;
        root_next         = root_reg;
        out_valid_next    = out_acc ? 1'b0 : out_valid_reg;
        sel_next          = sel_reg;
        found_next        = found_reg;
        ovf_out_next      = ovf_out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    v_next     = v_in;
                    win_next   = win_rate;
                    draw_next  = draw_rate;
                    prior_next = prior;
                    vl_next    = pending_loss;
                    last_next  = last;
                    if (!action)
                    begin
                        // load radicand visits * 2^16 at the top
                        sh_next    = SHW'({v_in, 16'b0}) << (SHW - 2 * RB);
                        rem_next   = '0;
                        root_next  = '0;
                        cnt_next   = CW'(RB);
                        state_next = S_SQRT;
                    end
                    else if (pos_reg >= PB'(EDGE_LIMIT))
                    begin
                        ovf_next   = 1'b1;
                        state_next = last ? S_FIN : S_IDLE;
                    end
                    else if (proven)
                    begin
                        pos_next   = pos_reg + PB'(1);
                        state_next = last ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_SQRT:
            begin
                rem_next  = step_ok ? step_diff : RW'(partial);
                root_next = {root_reg[RB-2:0], step_ok};
                sh_next   = {sh_reg[SHW-3:0], 2'b00};
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    state_next = S_HMUL;
            end
            S_HMUL:
            begin
                // scale, saturate, and start a fresh selection
                if (t_val > TW'(32'hFFFF_FFFF))
                    sqrt_term_next = '1;
                else
                    sqrt_term_next = pes_pkg::TERM_W'(t_val);
                parent_value_next = base_c;
                best_score_next   = '0;
                best_index_next   = '0;
                any_found_next    = 1'b0;
                pos_next          = '0;
                ovf_next          = 1'b0;
                state_next        = S_IDLE;
            end
            S_PREP:
            begin
                base_next  = base_c;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                unum_next = u_prod[47:16];
                if (v_reg == '0 && !unvisited_mode_reg)
                begin
                    q_next     = parent_value_reg;
                    state_next = S_USTRT;
                end
                else if (vl_reg == '0)
                begin
                    q_next     = base_reg;
                    state_next = S_USTRT;
                end
                else
                begin
                    // quotient fits 17 bits, so the upper part is the first remainder
                    rem_next   = RW'(qnum[NW-1:QW]);
                    sh_next    = SHW'(qnum[QW-1:0]) << (SHW - QW);
                    dvs_next   = RW'(v_reg) + RW'(vl_reg);
                    cnt_next   = CW'(QW);
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                rem_next = step_ok ? step_diff : RW'(partial);
                sh_next  = {sh_reg[SHW-2:0], step_ok};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    q_next     = {sh_reg[QW-2:0], step_ok};
                    state_next = S_USTRT;
                end
            end
            S_USTRT:
            begin
                rem_next   = '0;
                sh_next    = SHW'(unum_reg) << (SHW - 32);
                dvs_next   = RW'(v_reg) + RW'(1);
                cnt_next   = CW'(32);
                state_next = S_UDIV;
            end
            S_UDIV:
            begin
                rem_next = step_ok ? step_diff : RW'(partial);
                sh_next  = {sh_reg[SHW-2:0], step_ok};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    state_next = S_SCORE;
            end
            S_SCORE:
            begin
                // strictly greater wins, ties keep the earlier edge
                if (!any_found_reg || score > best_score_reg)
                begin
                    best_score_next = score;
                    best_index_next = pes_pkg::INDEX_W'(pos_reg);
                    any_found_next  = 1'b1;
                end
                pos_next   = pos_reg + PB'(1);
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    sel_next        = any_found_reg ? best_index_reg : '0;
                    found_next      = any_found_reg;
                    ovf_out_next    = ovf_reg;
                    best_score_next = '0;
                    best_index_next = '0;
                    any_found_next  = 1'b0;
                    pos_next        = '0;
                    ovf_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exploration_reg    <= pes_pkg::EXPLORATION_RST;
            style_weight_reg   <= pes_pkg::STYLE_WEIGHT_RST;
            unvisited_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pes_pkg::REG_EXPLORATION:    exploration_reg    <= cfg_data;
                pes_pkg::REG_STYLE_WEIGHT:   style_weight_reg   <= cfg_data;
                pes_pkg::REG_UNVISITED_MODE: unvisited_mode_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // control and node state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            sqrt_term_reg    <= '0;
            parent_value_reg <= '0;
            best_score_reg   <= '0;
            best_index_reg   <= '0;
            any_found_reg    <= 1'b0;
            pos_reg          <= '0;
            ovf_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            sqrt_term_reg    <= sqrt_term_next;
            parent_value_reg <= parent_value_next;
            best_score_reg   <= best_score_next;
            best_index_reg   <= best_index_next;
            any_found_reg    <= any_found_next;
            pos_reg          <= pos_next;
            ovf_reg          <= ovf_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        v_reg       <= v_next;
        win_reg     <= win_next;
        draw_reg    <= draw_next;
        prior_reg   <= prior_next;
        vl_reg      <= vl_next;
        last_reg    <= last_next;
        base_reg    <= base_next;
        q_reg       <= q_next;
        unum_reg    <= unum_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        sh_reg      <= sh_next;
        root_reg    <= root_next;
        sel_reg     <= sel_next;
        found_reg   <= found_next;
        ovf_out_reg <= ovf_out_next;
    end

    `ASSERT_CLK(a_pos_bound, clk, rst_n, pos_reg <= PB'(EDGE_LIMIT), "edge position past limit")
    `ASSERT_CLK(a_idx_clear, clk, rst_n, !any_found_reg |-> best_index_reg == '0, "stale index")
    `ASSERT_CLK(a_loop_cnt, clk, rst_n, loop_active |-> cnt_reg != '0, "iteration count ran out")
    `ASSERT_CLK(a_found_sel, clk, rst_n, out_valid_reg && !found_reg |-> sel_reg == '0, "bad index")

endmodule
